/* hdl/smps_pkg.sv */
// Shared types and constants for the subinterval max-product sum core.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package smps_pkg;

   // fixed field widths of the stream words
   localparam int POS_W        = 13;
   localparam int FIELD_VAL_W  = 16;
   localparam int COUNT_W      = 13;
   localparam int SUM_W        = 63;
   localparam int REQ_TDATA_W  = 72;
   localparam int RSP_TDATA_W  = 64;

   // request kinds carried in req_tuser
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // response status carried in rsp_tuser
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_FINISH
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // write one value pair
      logic capture;   // latch query bounds, clear the sum
      logic issue;     // read the next (p,q) pair and advance
      logic publish;   // move the result into the response register
   } smps_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic query_bad;   // captured query was rejected
      logic last_pair;   // current pair is the final one of the query
      logic pipe_empty;  // no pair left in the max/multiply/sum pipeline
      logic rsp_free;    // response register can take a new word
   } smps_stat_type;

endpackage

`default_nettype wire

/* hdl/smps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds one value store of the core.
`default_nettype none

module smps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* hdl/smps_ctrl.sv */
// Controller state machine of the subinterval max-product sum core.
// Depends on smps_pkg; drives commands to smps_dp and reads its status.
`default_nettype none

module smps_ctrl
   import smps_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid_i,
   input  wire logic          req_kind_i,
   output      logic          req_ready_o,
   input  wire smps_stat_type stat_i,
   output      smps_cmd_type  cmd_o
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid_i && (req_kind_i == CMD_QUERY)) state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (stat_i.query_bad) state_in = ST_FINISH;
            else if (stat_i.last_pair) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (stat_i.pipe_empty) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat_i.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready_o   = 1'b0;
      cmd_o         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready_o   = 1'b1;
            cmd_o.load    = req_valid_i && (req_kind_i == CMD_LOAD);
            cmd_o.capture = req_valid_i && (req_kind_i == CMD_QUERY);
         end
         ST_SWEEP: begin
            cmd_o.issue = !stat_i.query_bad;
         end
         ST_DRAIN: begin
            cmd_o = '0;
         end
         ST_FINISH: begin
            cmd_o.publish = stat_i.rsp_free;
         end
         default: cmd_o = '0;
      endcase
   end

`ifndef SYNTH
   a_publish_drained: assert property (@(posedge clock) disable iff (reset)
      cmd_o.publish |-> stat_i.pipe_empty)
      else $error("result published while pairs still in flight");

   a_last_to_drain: assert property (@(posedge clock) disable iff (reset)
      (cmd_o.issue && stat_i.last_pair) |=> (state_ff == ST_DRAIN))
      else $error("sweep did not end after the final pair");
`endif

endmodule

`default_nettype wire

/* hdl/smps_dp.sv */
// Datapath of the subinterval max-product sum core: value stores, pair
// counters, running maxima, multiplier, saturating sum and response register.
// Depends on smps_pkg and smps_ram.
`default_nettype none

module smps_dp
   import smps_pkg::*;
#(
   parameter int MAX_LEN    = 4096,
   parameter int VALUE_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire smps_cmd_type       cmd_i,
   output      smps_stat_type      stat_o,
   input  wire logic [POS_W-1:0]   position_i,
   input  wire logic [FIELD_VAL_W-1:0] first_value_i,
   input  wire logic [FIELD_VAL_W-1:0] second_value_i,
   input  wire logic [POS_W-1:0]   left_bound_i,
   input  wire logic [POS_W-1:0]   right_bound_i,
   input  wire logic               csr_valid_i,
   input  wire logic [COUNT_W-1:0] csr_data_i,
   input  wire logic               rsp_ready_i,
   output      logic               rsp_valid_o,
   output      logic [SUM_W-1:0]   rsp_sum_o,
   output      logic               rsp_status_o
);

   localparam int ADDR_W = $clog2(MAX_LEN);
   localparam int CMP_W  = (ADDR_W + 1 > POS_W) ? ADDR_W + 1 : POS_W;
   localparam int PROD_W = 2 * VALUE_BITS;
   localparam logic [CMP_W-1:0] LEN_MAX = CMP_W'(MAX_LEN);
   localparam logic [SUM_W-1:0] SUM_LIMIT = '1;

   logic [COUNT_W-1:0] count_ff, count_in;

   // load path
   logic [CMP_W-1:0]  pos_ext, pos_m1;
   logic              load_ok;
   logic [VALUE_BITS+FIELD_VAL_W-1:0] first_wide, second_wide;
   logic [VALUE_BITS-1:0] first_wr, second_wr;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   // query bounds and pair counters
   logic [CMP_W-1:0] lft_ext, rgt_ext, limit;
   logic [CMP_W-1:0] p_ff, p_in, q_ff, q_in, rgt_ff, rgt_in, q_m1;
   logic             bad_ff, bad_in;

   // pipeline
   logic [VALUE_BITS-1:0] rd_first, rd_second;
   logic             rd_v_ff, rd_v_in, rd_row_ff, rd_row_in;
   logic [VALUE_BITS-1:0] m1_ff, m1_in, m2_ff, m2_in;
   logic             mv_ff, mv_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic             pv_ff, pv_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W:0]   sum_wide;

   logic             rsp_valid_ff, rsp_valid_in, rsp_status_ff, rsp_status_in;
   logic [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;

   always_comb begin
      count_in = csr_valid_i ? csr_data_i : count_ff;
   end

   // load: drop positions of zero or past the store depth
   always_comb begin
      pos_ext     = CMP_W'(position_i);
      pos_m1      = pos_ext - CMP_W'(1);
      load_ok     = (pos_ext != '0) && (pos_ext <= LEN_MAX);
      wr_addr     = pos_m1[ADDR_W-1:0];
      first_wide  = {{VALUE_BITS{1'b0}}, first_value_i};
      second_wide = {{VALUE_BITS{1'b0}}, second_value_i};
      first_wr    = first_wide[VALUE_BITS-1:0];
      second_wr   = second_wide[VALUE_BITS-1:0];
   end

   // bounds check and pair sequencing: q runs p..rgt, then p advances
   always_comb begin
      lft_ext = CMP_W'(left_bound_i);
      rgt_ext = CMP_W'(right_bound_i);
      limit   = (CMP_W'(count_ff) < LEN_MAX) ? CMP_W'(count_ff) : LEN_MAX;
      q_m1    = q_ff - CMP_W'(1);
      rd_addr = q_m1[ADDR_W-1:0];

      p_in   = p_ff;
      q_in   = q_ff;
      rgt_in = rgt_ff;
      bad_in = bad_ff;
      if (cmd_i.capture) begin
         p_in   = lft_ext;
         q_in   = lft_ext;
         rgt_in = rgt_ext;
         bad_in = (lft_ext == '0) || (lft_ext > rgt_ext) || (rgt_ext > limit);
      end else if (cmd_i.issue) begin
         if (q_ff == rgt_ff) begin
            p_in = p_ff + CMP_W'(1);
            q_in = p_ff + CMP_W'(1);
         end else begin
            q_in = q_ff + CMP_W'(1);
         end
      end
      rd_v_in   = cmd_i.issue;
      rd_row_in = (q_ff == p_ff);
   end

   // running maxima restart at the first pair of each row
   always_comb begin
      mv_in = rd_v_ff;
      m1_in = m1_ff;
      m2_in = m2_ff;
      if (rd_v_ff) begin
         m1_in = (rd_row_ff || (rd_first > m1_ff)) ? rd_first : m1_ff;
         m2_in = (rd_row_ff || (rd_second > m2_ff)) ? rd_second : m2_ff;
      end
      pv_in   = mv_ff;
      prod_in = PROD_W'(m1_ff) * PROD_W'(m2_ff);
   end

   // saturating sum
   always_comb begin
      sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(prod_ff);
      sum_in   = sum_ff;
      if (cmd_i.capture) begin
         sum_in = '0;
      end else if (pv_ff) begin
         sum_in = sum_wide[SUM_W] ? SUM_LIMIT : sum_wide[SUM_W-1:0];
      end
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready_i;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd_i.publish) begin
         rsp_valid_in  = 1'b1;
         rsp_sum_in    = bad_ff ? '0 : sum_ff;
         rsp_status_in = bad_ff ? STATUS_BAD : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         rd_v_ff      <= 1'b0;
         mv_ff        <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bad_ff       <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_v_ff      <= rd_v_in;
         mv_ff        <= mv_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
         bad_ff       <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff          <= p_in;
      q_ff          <= q_in;
      rgt_ff        <= rgt_in;
      rd_row_ff     <= rd_row_in;
      m1_ff         <= m1_in;
      m2_ff         <= m2_in;
      prod_ff       <= prod_in;
      sum_ff        <= sum_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   smps_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_LEN)
   ) u_first_store (
      .clock      (clock),
      .wr_en      (cmd_i.load && load_ok),
      .wr_addr    (wr_addr),
      .wr_data    (first_wr),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_first)
   );

   smps_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_LEN)
   ) u_second_store (
      .clock      (clock),
      .wr_en      (cmd_i.load && load_ok),
      .wr_addr    (wr_addr),
      .wr_data    (second_wr),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_second)
   );

   always_comb begin
      stat_o.query_bad  = bad_ff;
      stat_o.last_pair  = (p_ff == rgt_ff) && (q_ff == rgt_ff);
      stat_o.pipe_empty = !rd_v_ff && !mv_ff && !pv_ff;
      stat_o.rsp_free   = !rsp_valid_ff || rsp_ready_i;
   end

   assign rsp_valid_o  = rsp_valid_ff;
   assign rsp_sum_o    = rsp_sum_ff;
   assign rsp_status_o = rsp_status_ff;

`ifndef SYNTH
   a_rsp_from_publish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd_i.publish))
      else $error("response appeared without a publish");

   a_pair_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd_i.issue |-> ((p_ff <= q_ff) && (q_ff <= rgt_ff)))
      else $error("pair counters outside the query bounds");

   a_sum_grows: assert property (@(posedge clock) disable iff (reset)
      (pv_ff && !cmd_i.capture) |=> (sum_ff >= $past(sum_ff)))
      else $error("running sum decreased");
`endif

endmodule

`default_nettype wire

/* hdl/subinterval_max_product_sum_core.sv */
// Top level of the subinterval max-product sum core.
// Depends on smps_pkg, smps_ctrl, smps_dp (which holds two smps_ram stores).
//
//  channel | direction | tdata / data (low bit up)                       | tuser
//  --------+-----------+-------------------------------------------------+-----------
//  req     | in        | position, first_value, second_value,            | cmd
//          |           | left_bound, right_bound, one zero pad bit       |
//  rsp     | out       | product_sum, one zero pad bit                   | status
//  csr     | in        | element_count                                   | -
//
//  A load word is written while the controller is idle. A query over n =
//  right_bound - left_bound + 1 positions is captured, then reads n*(n+1)/2
//  pairs, one per cycle from the two store read ports; the max/multiply/sum
//  pipeline drains and the result is published; a rejected query reads none.
//  Reset clears the controller, pipeline valids and response valid, and sets
//  element_count to 1; the value stores hold nothing defined until loaded.
//  A finished result waits in the response register while the next request
//  word is taken; a further query stalls at its end until that slot frees.
`default_nettype none

module subinterval_max_product_sum_core
   import smps_pkg::*;
#(
   parameter int MAX_LEN    = 4096,
   parameter int VALUE_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request: position[12:0], first_value[28:13], second_value[44:29],
   //          left_bound[57:45], right_bound[70:58], pad[71]
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // request kind: cmd[0]
   input  wire logic                   req_tuser,
   // response: product_sum[62:0], pad[63]
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [RSP_TDATA_W-1:0] rsp_tdata,
   // response flag: status[0]
   output      logic                   rsp_tuser,
   // element_count write
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [COUNT_W-1:0]     csr_data
);

   smps_cmd_type  cmd;
   smps_stat_type stat;
   logic [SUM_W-1:0] rsp_sum;

   // user must write configuration only while idle; not enforced, taken at once
   assign csr_ready = 1'b1;

   smps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid_i (req_tvalid),
      .req_kind_i  (req_tuser),
      .req_ready_o (req_tready),
      .stat_i      (stat),
      .cmd_o       (cmd)
   );

   smps_dp #(
      .MAX_LEN    (MAX_LEN),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd_i          (cmd),
      .stat_o         (stat),
      .position_i     (req_tdata[12:0]),
      .first_value_i  (req_tdata[28:13]),
      .second_value_i (req_tdata[44:29]),
      .left_bound_i   (req_tdata[57:45]),
      .right_bound_i  (req_tdata[70:58]),
      .csr_valid_i    (csr_valid),
      .csr_data_i     (csr_data),
      .rsp_ready_i    (rsp_tready),
      .rsp_valid_o    (rsp_tvalid),
      .rsp_sum_o      (rsp_sum),
      .rsp_status_o   (rsp_tuser)
   );

   // pad the sum to a whole number of bytes
   assign rsp_tdata = {1'b0, rsp_sum};

endmodule

`default_nettype wire

/* sim/smps_checker.sv */
// Scoreboard for the subinterval max-product sum core: mirrors the value stores
// and element_count, predicts each query result and compares it with the response.
// Depends on smps_pkg.
`timescale 1ns / 100ps
`default_nettype none

module smps_checker
   import smps_pkg::*;
#(
   parameter int MAX_LEN = 4096
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   req_tuser,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                   rsp_tuser,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [COUNT_W-1:0]     csr_data,
   output int                          error_count,
   output int                          pending
);

   typedef struct packed {
      logic [SUM_W-1:0] product_sum;
      logic             status;
   } range_result_type;

   localparam longint unsigned SUM_CEILING = 64'h7FFF_FFFF_FFFF_FFFF;

   logic [FIELD_VAL_W-1:0] first_copy  [MAX_LEN];
   logic [FIELD_VAL_W-1:0] second_copy [MAX_LEN];
   logic [COUNT_W-1:0]     count_copy = COUNT_RESET;
   range_result_type       result_q [$];
   int                     errors = 0;

   initial begin
      error_count = 0;
      pending     = 0;
   end

   // sum over every [p,q] inside [lo,hi] of max(first) * max(second)
   function automatic range_result_type range_product_sum(input int unsigned lo,
                                                          input int unsigned hi);
      int unsigned      limit;
      int unsigned      p;
      int unsigned      q;
      longint unsigned  acc;
      longint unsigned  peak1;
      longint unsigned  peak2;
      longint unsigned  prod;
      bit               saturated;
      range_result_type r;
      limit = (count_copy > MAX_LEN) ? MAX_LEN : count_copy;
      r.status      = STATUS_OK;
      r.product_sum = '0;
      acc       = 0;
      saturated = 1'b0;
      if (lo == 0 || lo > hi || hi > limit) begin
         r.status = STATUS_BAD;
         return r;
      end
      for (p = lo; p <= hi && !saturated; p++) begin
         peak1 = 0;
         peak2 = 0;
         for (q = p; q <= hi; q++) begin
            if (first_copy[q-1] > peak1) peak1 = first_copy[q-1];
            if (second_copy[q-1] > peak2) peak2 = second_copy[q-1];
            prod = peak1 * peak2;
            if (acc > SUM_CEILING - prod) begin
               acc       = SUM_CEILING;
               saturated = 1'b1;
               break;
            end
            acc += prod;
         end
      end
      r.product_sum = acc[SUM_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      range_result_type want;
      logic [POS_W-1:0] pos;
      if (reset) begin
         count_copy = COUNT_RESET;
         result_q.delete();
      end else begin
         // retire first: a response here always belongs to an older query
         if (rsp_tvalid && rsp_tready) begin
            if (result_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none, actual sum %0d status %0d",
                        $time, rsp_tdata[SUM_W-1:0], rsp_tuser);
            end else begin
               want = result_q.pop_front();
               if (rsp_tdata[SUM_W-1:0] !== want.product_sum) begin
                  errors++;
                  $display("%0t: product_sum mismatch, expected %0d, actual %0d",
                           $time, want.product_sum, rsp_tdata[SUM_W-1:0]);
               end
               if (rsp_tuser !== want.status) begin
                  errors++;
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_tuser);
               end
            end
         end
         if (csr_valid && csr_ready) count_copy = csr_data;
         if (req_tvalid && req_tready) begin
            pos = req_tdata[POS_W-1:0];
            if (req_tuser == CMD_LOAD) begin
               if (pos >= 1 && pos <= MAX_LEN) begin
                  first_copy[pos-1]  = req_tdata[POS_W +: FIELD_VAL_W];
                  second_copy[pos-1] = req_tdata[POS_W+FIELD_VAL_W +: FIELD_VAL_W];
               end
            end else begin
               result_q.push_back(range_product_sum(
                  req_tdata[POS_W+2*FIELD_VAL_W +: POS_W],
                  req_tdata[2*POS_W+2*FIELD_VAL_W +: POS_W]));
            end
         end
      end
      pending     <= result_q.size();
      error_count <= errors;
   end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Testbench top for the subinterval max-product sum core: drives load and query
// words, element_count writes and response back-pressure, and reports the verdict.
// Depends on smps_pkg, subinterval_max_product_sum_core and smps_checker.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
   import smps_pkg::*;

   localparam int MAX_LEN       = 4096;
   localparam int VALUE_BITS    = 16;
   localparam int SETTLE_CYCLES = 16;      // beyond the capture/drain/publish latency
   localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
   localparam int QUIET_LIMIT   = 100_000; // longest query used here spans 64 positions

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = CMD_LOAD;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [COUNT_W-1:0]     csr_data   = '0;

   int  error_count;
   int  pending;
   int  quiet_cycles = 0;
   int  live_items   = 0;   // words the block acts on (ignored loads excluded)
   bit  idle_on      = 1'b1;
   bit  hold_rsp     = 1'b0;

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   subinterval_max_product_sum_core #(
      .MAX_LEN    (MAX_LEN),
      .VALUE_BITS (VALUE_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   smps_checker #(
      .MAX_LEN (MAX_LEN)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .error_count (error_count),
      .pending     (pending)
   );

   // Receiver: random back-pressure (only while idling is on), or a long hold-off
   // on request from the stimulus. The hold-off is counted here so the sender keeps
   // offering words and the block backs up into its input.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= !idle_on || ($urandom_range(99) >= 15);
         end
      end
   end

   // Watchdog: end the run if no channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request word and hold it until accepted. Random idle cycles go
   // in front of it while idling is on; valid stays high between back-to-back words.
   task automatic push_request(input logic kind, input logic [POS_W-1:0] pos,
                               input logic [FIELD_VAL_W-1:0] v1,
                               input logic [FIELD_VAL_W-1:0] v2,
                               input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi);
      while (idle_on && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      // pad, right_bound, left_bound, second_value, first_value, position
      req_tdata  <= {1'b0, hi, lo, v2, v1, pos};
      do @(posedge clock); while (!req_tready);
      if (!(kind == CMD_LOAD && (pos == 0 || pos > MAX_LEN))) live_items++;
   endtask

   // Unused fields of each word carry random bits so every field bit toggles (the pad bit stays zero).
   task automatic load_pair(input int unsigned pos, input logic [FIELD_VAL_W-1:0] v1,
                            input logic [FIELD_VAL_W-1:0] v2);
      push_request(CMD_LOAD, POS_W'(pos), v1, v2, POS_W'($urandom), POS_W'($urandom));
   endtask

   task automatic ask_range(input int unsigned lo, input int unsigned hi);
      push_request(CMD_QUERY, POS_W'($urandom), FIELD_VAL_W'($urandom),
                   FIELD_VAL_W'($urandom), POS_W'(lo), POS_W'(hi));
   endtask

   // Drop valid, wait for every expected response, then let the pipeline
   // drain of any trailing load before touching the register.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_element_count(input int unsigned value);
      settle_block();
      csr_valid <= 1'b1;
      csr_data  <= COUNT_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mix of extremes, ties and full-range random values.
   function automatic logic [FIELD_VAL_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return FIELD_VAL_W'($urandom_range(15));
         default: return FIELD_VAL_W'($urandom);
      endcase
   endfunction

   // One random phase: mostly well-formed runs (load a contiguous block, then
   // query inside it, so no unwritten entry is ever read), plus some noise:
   // ignored loads and queries that are always rejected.
   task automatic run_random_phase(input int unsigned count_value, input int unsigned quota,
                                   input bit with_hold, input bit steady);
      int unsigned limit;
      int unsigned start;
      int unsigned base;
      int unsigned len;
      int unsigned lo;
      int unsigned hi;
      int unsigned nq;
      set_element_count(count_value);
      limit   = (count_value > MAX_LEN) ? MAX_LEN : count_value;
      idle_on = !steady;
      if (with_hold) hold_rsp = 1'b1;
      start = live_items;
      while (live_items - start < quota) begin
         if ($urandom_range(99) < 20) begin
            case ($urandom_range(3))
               0: load_pair($urandom_range(1) ? 0 : $urandom_range(8191, MAX_LEN + 1),
                            pick_value(), pick_value());
               1: ask_range(0, $urandom_range(8191));
               2: begin
                  lo = $urandom_range(8191, 1);
                  ask_range(lo, $urandom_range(lo - 1, 0));
               end
               default: ask_range($urandom_range(8191, 1), $urandom_range(8191, limit + 1));
            endcase
         end else begin
            // most runs are short; a few are long to exercise deep sweeps
            len = ($urandom_range(19) == 0) ? $urandom_range(64, 24) : $urandom_range(12, 1);
            if (len > limit) len = limit;
            base = $urandom_range(limit - len + 1, 1);
            for (int unsigned i = 0; i < len; i++) load_pair(base + i, pick_value(), pick_value());
            nq = $urandom_range(3, 1);
            repeat (nq) begin
               lo = $urandom_range(base + len - 1, base);
               hi = $urandom_range(base + len - 1, lo);
               ask_range(lo, hi);
            end
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // element_count at its reset value of one
      load_pair(1, 16'hFFFF, 16'hFFFF);
      ask_range(1, 1);
      ask_range(1, 2);                       // right bound beyond element_count
      ask_range(0, 1);                       // left bound of zero
      load_pair(0, 16'h1234, 16'h5678);      // ignored: position zero
      load_pair(MAX_LEN + 1, 16'hAAAA, 16'h5555);
      load_pair(8191, 16'h0001, 16'h0001);
      ask_range(1, 1);

      // element_count at the store depth; fill the top end of the stores
      set_element_count(MAX_LEN);
      load_pair(MAX_LEN - 6, 16'h0000, 16'hFFFF);
      load_pair(MAX_LEN - 5, 16'hFFFF, 16'h0000);
      load_pair(MAX_LEN - 4, 16'h8000, 16'h8000);
      load_pair(MAX_LEN - 3, 16'h0001, 16'h7FFF);
      load_pair(MAX_LEN - 2, 16'h7FFF, 16'h0001);
      load_pair(MAX_LEN - 1, 16'hFFFF, 16'hFFFF);
      load_pair(MAX_LEN, 16'h0000, 16'h0000);
      ask_range(MAX_LEN - 6, MAX_LEN);
      ask_range(MAX_LEN, MAX_LEN);
      ask_range(MAX_LEN, MAX_LEN + 1);       // beyond the store depth
      ask_range(MAX_LEN, MAX_LEN - 1);       // bounds out of order
      load_pair(2, 16'h0000, 16'h0000);      // fill position 2 before querying [1,2]
      ask_range(1, 2);

      // zero element_count rejects every query
      set_element_count(0);
      ask_range(1, 1);
      ask_range(MAX_LEN, MAX_LEN);

      // random phases: pressure, a stretch with no idling, the smallest count, a small random count
      run_random_phase($urandom_range(MAX_LEN - 1, 2), 15, 1'b1, 1'b0);
      run_random_phase(MAX_LEN, 15, 1'b0, 1'b1);
      run_random_phase(1, 15, 1'b0, 1'b0);
      run_random_phase($urandom_range(200, 2), 15, 1'b0, 1'b0);

      settle_block();
      if (error_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
hdl/smps_pkg.sv
hdl/smps_ram.sv
hdl/smps_ctrl.sv
hdl/smps_dp.sv
hdl/subinterval_max_product_sum_core.sv
sim/smps_checker.sv
sim/tb_top.sv
